// ----- design/xcfr_pkg.sv -----
// Shared types and constants of the XOR-checked frame receiver.
package xcfr_pkg;

    // Frame phases
    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_DATA  = 2'd1;
    localparam logic [1:0] PH_CHECK = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_PAY = 2'd0;
    localparam logic [1:0] KIND_OK  = 2'd1;
    localparam logic [1:0] KIND_REP = 2'd2;

    // Byte codes
    localparam logic [7:0] SYNC_VALUE  = 8'hB0;
    localparam logic [7:0] SYNC_MASK   = 8'hF0;
    localparam logic [7:0] RESP_OK     = 8'hDD;
    localparam logic [7:0] RESP_REPEAT = 8'hDB;

    localparam int STORE_DEPTH = 15;

    // Controller to datapath commands
    typedef struct packed {
        logic take;      // input transfer this cycle
        logic emit_ok;   // load ok response into output register
        logic emit_rep;  // load repeat request into output register
        logic emit_pay;  // load next stored payload byte
        logic rd_start;  // restart payload readout at entry zero
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic       skip;
        logic [1:0] phase;
        logic       start_good;
        logic       cks_match;
        logic       len_zero;
        logic       rd_last;
        logic       out_free;
    } t_status;

endpackage

// ----- design/xor_checked_frame_receiver_top.sv -----
// Top level of the XOR-checked frame receiver.
//
// Input channel (i_in_valid / o_in_ready) carries one received byte per
// transfer with a chunk-end flag. Output channel (o_out_valid / i_out_ready)
// carries results: ok response, repeat request or stored payload byte, with
// o_last on the final result caused by one input byte.
// Good start bytes, payload bytes and dropped bytes produce nothing.
// A bad start byte or a bad checksum shows a repeat request in the cycle after
// its transfer. A good checksum shows the ok response in the cycle after its
// transfer, then the N payload bytes one per cycle while the output is not
// stalled, from the payload store's registered read port; no input is taken
// during that readout. Any byte is taken only when the output register is free
// or being emptied in the same cycle.
// When the receiver stalls, the output register holds its result and the
// readout pauses. Reset returns to awaiting a start byte, clears the skip
// flag and empties the output register; the payload store is not cleared.
module xor_checked_frame_receiver_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_chunk_end,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_kind,
    output logic [7:0] o_out_byte,
    output logic       o_last
);
    import xcfr_pkg::*;

    t_cmd    cmd;
    t_status status;

    xcfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    xcfr_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_byte   (i_rx_byte),
        .i_chunk_end (i_chunk_end),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_kind      (o_kind),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

endmodule

// ----- design/xcfr_datapath.sv -----
// Datapath: frame registers, payload store, readout counter and output register.
module xcfr_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_chunk_end,
    input  logic             i_out_ready,
    input  xcfr_pkg::t_cmd    i_cmd,
    output xcfr_pkg::t_status o_status,
    output logic             o_out_valid,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_out_byte,
    output logic             o_last
);
    import xcfr_pkg::*;

    logic [1:0] r_phase, n_phase;
    logic [3:0] r_len, n_len;
    logic [3:0] r_count, n_count;
    logic [7:0] r_xor, n_xor;
    logic       r_skip, n_skip;
    logic [3:0] r_rd_idx, n_rd_idx;
    logic [7:0] r_rd_data;
    logic [7:0] r_mem [0:STORE_DEPTH-1];
    logic       r_out_valid, n_out_valid;
    logic [1:0] r_kind, n_kind;
    logic [7:0] r_byte, n_byte;
    logic       r_last, n_last;

    logic [3:0] count_inc;
    logic       start_good;
    logic       cks_match;
    logic       rd_last;
    logic       wr_en;

    assign count_inc  = r_count + 4'd1;
    assign start_good = (i_rx_byte & SYNC_MASK) == SYNC_VALUE;
    assign cks_match  = i_rx_byte == r_xor;
    assign rd_last    = r_rd_idx == (r_len - 4'd1);
    assign wr_en      = i_cmd.take && !r_skip && (r_phase == PH_DATA);

    assign o_status.skip       = r_skip;
    assign o_status.phase      = r_phase;
    assign o_status.start_good = start_good;
    assign o_status.cks_match  = cks_match;
    assign o_status.len_zero   = r_len == 4'd0;
    assign o_status.rd_last    = rd_last;
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    // Advance frame state on each input transfer
    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_count = r_count;
        n_xor   = r_xor;
        n_skip  = r_skip;
        if (i_cmd.take) begin
            if (r_skip) begin
                if (i_chunk_end) begin
                    n_skip = 1'b0;
                end
            end else begin
                case (r_phase)
                    PH_DATA: begin
                        n_count = count_inc;
                        n_xor   = r_xor ^ i_rx_byte;
                        if (count_inc == r_len) begin
                            n_phase = PH_CHECK;
                        end
                    end
                    PH_CHECK: begin
                        n_phase = PH_START;
                        if (!cks_match) begin
                            n_skip = !i_chunk_end;
                        end
                    end
                    default: begin
                        if (!start_good) begin
                            n_phase = PH_START;
                            n_skip  = !i_chunk_end;
                        end else begin
                            n_len   = i_rx_byte[3:0];
                            n_xor   = 8'h00;
                            n_count = 4'd0;
                            n_phase = (i_rx_byte[3:0] == 4'd0) ? PH_CHECK : PH_DATA;
                        end
                    end
                endcase
            end
        end
    end

    // Step the readout counter
    always_comb begin
        n_rd_idx = r_rd_idx;
        if (i_cmd.rd_start) begin
            n_rd_idx = 4'd0;
        end else if (i_cmd.emit_pay) begin
            n_rd_idx = r_rd_idx + 4'd1;
        end
    end

    // Load the output register, drop it once transferred
    always_comb begin
        n_out_valid = r_out_valid;
        n_kind      = r_kind;
        n_byte      = r_byte;
        n_last      = r_last;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.emit_ok) begin
            n_out_valid = 1'b1;
            n_kind      = KIND_OK;
            n_byte      = RESP_OK;
            n_last      = r_len == 4'd0;
        end else if (i_cmd.emit_rep) begin
            n_out_valid = 1'b1;
            n_kind      = KIND_REP;
            n_byte      = RESP_REPEAT;
            n_last      = 1'b1;
        end else if (i_cmd.emit_pay) begin
            n_out_valid = 1'b1;
            n_kind      = KIND_PAY;
            n_byte      = r_rd_data;
            n_last      = rd_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_len       <= 4'd0;
            r_count     <= 4'd0;
            r_xor       <= 8'h00;
            r_skip      <= 1'b0;
            r_rd_idx    <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_len       <= n_len;
            r_count     <= n_count;
            r_xor       <= n_xor;
            r_skip      <= n_skip;
            r_rd_idx    <= n_rd_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload registers
    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_byte <= n_byte;
        r_last <= n_last;
    end

    // Payload store: one write port, registered read of the next entry
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count] <= i_rx_byte;
        end
        r_rd_data <= r_mem[n_rd_idx];
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_out_byte  = r_byte;
    assign o_last      = r_last;

endmodule

// ----- design/xcfr_ctrl.sv -----
// Controller: accepts bytes and sequences the response and payload readout.
module xcfr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  xcfr_pkg::t_status i_status,
    output logic              o_in_ready,
    output xcfr_pkg::t_cmd    o_cmd
);
    import xcfr_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic r_state, n_state;
    logic in_ready;

    assign in_ready = (r_state == S_IDLE) && i_status.out_free;

    // Decode commands for the datapath
    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.take     = i_in_valid && in_ready;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.take && !i_status.skip) begin
                    case (i_status.phase)
                        PH_DATA: begin
                        end
                        PH_CHECK: begin
                            if (i_status.cks_match) begin
                                o_cmd.emit_ok = 1'b1;
                                if (!i_status.len_zero) begin
                                    o_cmd.rd_start = 1'b1;
                                    n_state        = S_READ;
                                end
                            end else begin
                                o_cmd.emit_rep = 1'b1;
                            end
                        end
                        default: begin
                            if (!i_status.start_good) begin
                                o_cmd.emit_rep = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_READ: begin
                if (i_status.out_free) begin
                    o_cmd.emit_pay = 1'b1;
                    if (i_status.rd_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = in_ready;

endmodule

// ----- design/xcfr_checker.sv -----
// Port-level checker for the frame receiver, bound to the top level.
module xcfr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [1:0] o_kind,
    input logic [7:0] o_out_byte,
    input logic       o_last
);
    import xcfr_pkg::*;

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_kind) && $stable(o_out_byte) && $stable(o_last))
        else $error("stalled result changed");

    // No input is taken while a response sequence is still unfinished
    a_no_take_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> !o_in_ready)
        else $error("input taken during payload readout");

    // Repeat request is a single final result with its code
    a_rep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_REP) |-> o_last && (o_out_byte == RESP_REPEAT))
        else $error("bad repeat request");

    // Ok response carries its code
    a_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_OK) |-> (o_out_byte == RESP_OK))
        else $error("bad ok response");

endmodule

bind xor_checked_frame_receiver_top xcfr_checker u_xcfr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_kind      (o_kind),
    .o_out_byte  (o_out_byte),
    .o_last      (o_last)
);
